// ===== src/sbdc_pkg.sv =====
package sbdc_pkg;

   // Field widths of the request and response beats
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 9;

   typedef enum logic [KIND_W-1:0] {
      KIND_LEARN  = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_DECODE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // Controller state, one-hot
   typedef enum logic [1:0] {
      ST_IDLE    = 2'b01,
      ST_RESOLVE = 2'b10
   } state_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic               capture;
      logic               insert;
      kind_type           kind;
      logic [BYTE_W-1:0]  byte_value;
      logic [BYTE_W-1:0]  index_value;
      logic [COUNT_W-1:0] count;
   } bcast_type;

   // Handoff from a cell to its right-hand neighbor
   typedef struct packed {
      logic              lt;
      logic              lt_ff;
      logic [BYTE_W-1:0] key;
   } link_type;

   // Per-cell contribution to the result
   typedef struct packed {
      logic              eq;
      logic              pick;
      logic [BYTE_W-1:0] pos;
      logic [BYTE_W-1:0] key;
   } cell_res_type;

endpackage

// ===== src/sbdc_req_if.sv =====
interface sbdc_req_if;
   import sbdc_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] byte_value;
   logic [BYTE_W-1:0] index_value;

   modport source (output valid, kind, byte_value, index_value, input ready);
   modport sink   (input valid, kind, byte_value, index_value, output ready);
endinterface

// ===== src/sbdc_rsp_if.sv =====
interface sbdc_rsp_if;
   import sbdc_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  position;
   logic [BYTE_W-1:0]  byte_out;
   logic               hit;
   logic               table_full;
   logic [COUNT_W-1:0] key_count;

   modport source (output valid, position, byte_out, hit, table_full, key_count,
                   input ready);
   modport sink   (input valid, position, byte_out, hit, table_full, key_count,
                   output ready);
endinterface

// ===== src/sorted_byte_dictionary_coder_core.sv =====
// Channel  Dir  Beat fields                                          Accepted when
// req      in   kind, byte_value, index_value                        req.valid && req.ready
// rsp      out  position, byte_out, hit, table_full, key_count       rsp.valid && rsp.ready
//
// Each request has an accept and a resolve step: the accept edge loads per-cell compare
// flags across the whole row, the resolve step resolves the position and shifts the row.
// A row of MAX_KEYS cells holds the table; the count sets which cells are live.
// Reset clears the count and the handshake state; keys are not cleared.
// A waiting response does not block the next accept; only the resolve step
// waits until the response register is free.
module sorted_byte_dictionary_coder_core #(
   parameter int MAX_KEYS = 256
) (
   input logic       clock,
   input logic       reset,
   sbdc_req_if.sink  req,
   sbdc_rsp_if.source rsp
);
   import sbdc_pkg::*;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [BYTE_W-1:0]  index_ff, index_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_position_ff, rsp_position_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_full_ff, rsp_full_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               req_fire, resolve_fire;
   logic               present, has_room, insert_ok, decode_hit;
   logic [BYTE_W-1:0]  sel_pos, sel_key;
   logic [MAX_KEYS-1:0] eq_vec, pick_vec;

   bcast_type    bcast;
   link_type     link [MAX_KEYS+1];
   cell_res_type res  [MAX_KEYS];

   assign req_fire     = req.valid && req.ready;
   assign resolve_fire = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || rsp.ready);
   assign req.ready    = (state_ff == ST_IDLE);

   // Broadcast: live request payload on accept, held copy while resolving
   always_comb begin
      bcast.capture     = req_fire;
      bcast.insert      = resolve_fire && insert_ok;
      bcast.kind        = (state_ff == ST_IDLE) ? kind_type'(req.kind) : kind_ff;
      bcast.byte_value  = (state_ff == ST_IDLE) ? req.byte_value : byte_ff;
      bcast.index_value = (state_ff == ST_IDLE) ? req.index_value : index_ff;
      bcast.count       = count_ff;
   end

   // Row of cells; the leftmost neighbor acts as "below everything"
   assign link[0] = '{lt: 1'b1, lt_ff: 1'b1, key: '0};

   for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
      sbdc_cell #(.INDEX(i)) u_cell (
         .clock (clock),
         .bcast (bcast),
         .left  (link[i]),
         .right (link[i+1]),
         .res   (res[i])
      );
   end

   // Gather the picked cell's index and key; at most one cell is picked
   always_comb begin
      sel_pos = '0;
      sel_key = '0;
      for (int i = 0; i < MAX_KEYS; i++) begin
         sel_pos     = sel_pos | res[i].pos;
         sel_key     = sel_key | res[i].key;
         eq_vec[i]   = res[i].eq;
         pick_vec[i] = res[i].pick;
      end
      present = |eq_vec;
   end

   always_comb begin
      has_room   = count_ff < COUNT_W'(MAX_KEYS);
      insert_ok  = (kind_ff == KIND_LEARN) && !present && has_room;
      decode_hit = {1'b0, index_ff} < count_ff;
   end

   // Result of the item being resolved
   always_comb begin
      rsp_position_in = '0;
      rsp_byte_in     = '0;
      rsp_hit_in      = 1'b0;
      rsp_full_in     = 1'b0;
      count_in        = count_ff;
      case (kind_ff)
         KIND_LEARN: begin
            rsp_hit_in  = present;
            rsp_full_in = !present && !has_room;
            if (present || has_room) begin
               rsp_position_in = sel_pos;
            end
            if (insert_ok) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         KIND_ENCODE: begin
            rsp_hit_in = present;
            if (present) begin
               rsp_position_in = sel_pos;
            end
         end
         KIND_DECODE: begin
            rsp_hit_in = decode_hit;
            if (decode_hit) begin
               rsp_byte_in = sel_key;
            end
         end
         default: begin
         end
      endcase
      rsp_count_in = count_in;
   end

   // Controller
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      index_in = index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = kind_type'(req.kind);
               byte_in  = req.byte_value;
               index_in = req.index_value;
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (resolve_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (resolve_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (resolve_fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      index_ff <= index_in;
      if (resolve_fire) begin
         rsp_position_ff <= rsp_position_in;
         rsp_byte_ff     <= rsp_byte_in;
         rsp_hit_ff      <= rsp_hit_in;
         rsp_full_ff     <= rsp_full_in;
         rsp_count_ff    <= rsp_count_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.position   = rsp_position_ff;
   assign rsp.byte_out   = rsp_byte_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.table_full = rsp_full_ff;
   assign rsp.key_count  = rsp_count_ff;

   // The row stays sorted and distinct, so at most one cell is picked or equal
   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |-> $onehot0(pick_vec))
      else $error("more than one cell picked");

   a_eq_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |-> $onehot0(eq_vec))
      else $error("duplicate key in row");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_KEYS))
      else $error("key count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == $past(count_ff) + COUNT_W'(1)) && $past(bcast.insert))
      else $error("key count moved without an insert");

   a_hit_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_full_ff))
      else $error("hit and table_full both set");
endmodule

// ===== src/sbdc_cell.sv =====
module sbdc_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  sbdc_pkg::bcast_type    bcast,
   input  sbdc_pkg::link_type     left,
   output sbdc_pkg::link_type     right,
   output sbdc_pkg::cell_res_type res
);
   import sbdc_pkg::*;

   logic [BYTE_W-1:0] key_ff, key_in;
   logic              lt_ff, lt_in;
   logic              eq_ff, eq_in;
   logic              pick_ff, pick_in;
   logic              occupied, lt, eq, boundary, at_index;

   // Compare against the broadcast byte; the sorted row makes lt a prefix
   always_comb begin
      occupied = COUNT_W'(INDEX) < bcast.count;
      lt       = occupied && (key_ff < bcast.byte_value);
      eq       = occupied && (key_ff == bcast.byte_value);
      boundary = !lt && left.lt;
      at_index = BYTE_W'(INDEX) == bcast.index_value;
   end

   // Capture flags on accept, shift right or take the new byte on insert
   always_comb begin
      lt_in   = lt_ff;
      eq_in   = eq_ff;
      pick_in = pick_ff;
      key_in  = key_ff;
      if (bcast.capture) begin
         lt_in   = lt;
         eq_in   = eq;
         pick_in = (bcast.kind == KIND_DECODE) ? at_index : boundary;
      end
      if (bcast.insert) begin
         if (pick_ff) begin
            key_in = bcast.byte_value;
         end else if (!left.lt_ff) begin
            key_in = left.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      lt_ff   <= lt_in;
      eq_ff   <= eq_in;
      pick_ff <= pick_in;
   end

   assign right = '{lt: lt, lt_ff: lt_ff, key: key_ff};

   assign res.eq   = eq_ff;
   assign res.pick = pick_ff;
   assign res.pos  = pick_ff ? BYTE_W'(INDEX) : '0;
   assign res.key  = pick_ff ? key_ff : '0;
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sbdc_pkg::*;

   localparam int DICT_KEYS  = 256;
   localparam int QUIET_TAIL = 200;   // final beats with no idling on either side
   localparam int HOLD_AFTER = 200;   // responses checked before the long receiver hold
   localparam int HOLD_LEN   = 120;
   localparam int GROW_BEATS = 1000;
   localparam int FULL_BEATS = 450;

   typedef struct {
      kind_type          kind;
      logic [BYTE_W-1:0] byte_value;
      logic [BYTE_W-1:0] index_value;
      bit                wait_drain;   // hold this beat until every response is back
   } req_beat_type;

   typedef struct {
      logic [BYTE_W-1:0]  position;
      logic [BYTE_W-1:0]  byte_out;
      logic               hit;
      logic               table_full;
      logic [COUNT_W-1:0] key_count;
   } rsp_beat_type;

   logic clock;
   logic reset = 1'b1;

   sbdc_req_if req_ch ();
   sbdc_rsp_if rsp_ch ();

   sorted_byte_dictionary_coder_core #(
      .MAX_KEYS (DICT_KEYS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Request plan and the dictionary contents it implies at generation time
   req_beat_type pending_requests [$];
   bit           gen_present [256];
   int           gen_count = 0;

   // Predicted dictionary and the responses still owed
   logic [BYTE_W-1:0] dict_keys [DICT_KEYS];
   int                dict_count = 0;
   rsp_beat_type      expected_results [$];

   req_beat_type cur_req;
   rsp_beat_type predicted;
   rsp_beat_type want;
   int        send_gap = 0;
   int        stall_left = 0;
   int        hold_left = 0;
   bit        hold_done = 1'b0;
   int        accepted_cnt = 0;
   int        checked_cnt = 0;
   int        error_cnt = 0;
   int        total_items = 0;
   int        kind_seen [4] = '{0, 0, 0, 0};

   // Sorted-table behavior: lookup by lower bound, insert with shift, read by index
   task automatic dictionary_apply(input req_beat_type b, output rsp_beat_type r);
      int  p;
      int  k;
      bit  present;
      r = '{default: '0};
      case (b.kind)
         KIND_LEARN, KIND_ENCODE: begin
            p = 0;
            while (p < dict_count && dict_keys[p] < b.byte_value) p++;
            present = (p < dict_count) && (dict_keys[p] == b.byte_value);
            if (present) begin
               r.hit      = 1'b1;
               r.position = p[BYTE_W-1:0];
            end else if (b.kind == KIND_LEARN) begin
               if (dict_count >= DICT_KEYS) begin
                  r.table_full = 1'b1;
               end else begin
                  for (k = dict_count; k > p; k--) dict_keys[k] = dict_keys[k-1];
                  dict_keys[p] = b.byte_value;
                  dict_count++;
                  r.position = p[BYTE_W-1:0];
               end
            end
         end
         KIND_DECODE: begin
            if (b.index_value < dict_count) begin
               r.hit      = 1'b1;
               r.byte_out = dict_keys[b.index_value];
            end
         end
         default: ;
      endcase
      r.key_count = dict_count[COUNT_W-1:0];
   endtask

   function automatic void add_request(kind_type k, int bval, int ival, bit drain);
      req_beat_type b;
      b.kind        = k;
      b.byte_value  = bval[BYTE_W-1:0];
      b.index_value = ival[BYTE_W-1:0];
      b.wait_drain  = drain;
      pending_requests.push_back(b);
      if (k == KIND_LEARN && !gen_present[bval[7:0]] && gen_count < DICT_KEYS) begin
         gen_present[bval[7:0]] = 1'b1;
         gen_count++;
      end
   endfunction

   function automatic int pick_known_byte();
      int b;
      do b = $urandom_range(0, 255); while (!gen_present[b]);
      return b;
   endfunction

   // One random beat; learn_pct sets how fast the table grows
   function automatic void random_request(int learn_pct);
      int roll;
      int b;
      int ix;
      roll = $urandom_range(0, 99);
      if (roll < learn_pct) begin
         b = ($urandom_range(0, 49) == 0) ? 0 : $urandom_range(1, 255);
         add_request(KIND_LEARN, b, $urandom_range(0, 255), 1'b0);
      end else if (roll < learn_pct + (100 - learn_pct) * 45 / 100) begin
         // half the lookups aim at keys already held
         if (gen_count > 0 && $urandom_range(0, 1) == 1) b = pick_known_byte();
         else b = $urandom_range(0, 255);
         add_request(KIND_ENCODE, b, $urandom_range(0, 255), 1'b0);
      end else if (roll < 96) begin
         if (gen_count > 0 && $urandom_range(0, 4) != 0) ix = $urandom_range(0, gen_count - 1);
         else ix = $urandom_range(0, 255);
         add_request(KIND_DECODE, $urandom_range(0, 255), ix, 1'b0);
      end else begin
         add_request(KIND_NONE, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
      end
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         error_cnt++;
      end
   endfunction

   // Driver: offers planned beats, predicts each one on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.kind        <= '0;
         req_ch.byte_value  <= '0;
         req_ch.index_value <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            dictionary_apply(cur_req, predicted);
            expected_results.push_back(predicted);
            kind_seen[cur_req.kind]++;
            accepted_cnt++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         (pending_requests[0].wait_drain && expected_results.size() != 0)) begin
               req_ch.valid <= 1'b0;
            end else begin
               cur_req = pending_requests.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.kind        <= cur_req.kind;
               req_ch.byte_value  <= cur_req.byte_value;
               req_ch.index_value <= cur_req.index_value;
               if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
                  send_gap = $urandom_range(1, 17);
            end
         end
      end
   end

   // Monitor: checks each response beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("response beat with no request outstanding");
               error_cnt++;
            end else begin
               want = expected_results.pop_front();
               check_field("position", 16'(want.position), 16'(rsp_ch.position));
               check_field("byte_out", 16'(want.byte_out), 16'(rsp_ch.byte_out));
               check_field("hit", 16'(want.hit), 16'(rsp_ch.hit));
               check_field("table_full", 16'(want.table_full), 16'(rsp_ch.table_full));
               check_field("key_count", 16'(want.key_count), 16'(rsp_ch.key_count));
               checked_cnt++;
            end
         end
         // one long hold so the core backs up into the request side
         if (!hold_done && checked_cnt >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (checked_cnt < total_items - QUIET_TAIL && $urandom_range(0, 11) == 0)
               stall_left = $urandom_range(1, 17);
         end
      end
   end

   initial begin
      int missing [$];
      int j;
      int tmp;
      int n;

      // Directed: empty-table misses, unused kind, extremes, byte zero, duplicates
      add_request(KIND_ENCODE, 'h41, 'h00, 1'b0);
      add_request(KIND_DECODE, 'h00, 'h00, 1'b0);
      add_request(KIND_DECODE, 'hFF, 'hFF, 1'b0);
      add_request(KIND_NONE, 'h00, 'h00, 1'b0);
      add_request(KIND_LEARN, 'h80, 'h00, 1'b0);
      add_request(KIND_LEARN, 'h80, 'hFF, 1'b0);
      add_request(KIND_LEARN, 'hFF, 'h00, 1'b0);
      add_request(KIND_LEARN, 'h01, 'h00, 1'b0);
      add_request(KIND_LEARN, 'h00, 'h00, 1'b0);
      add_request(KIND_LEARN, 'h55, 'hAA, 1'b0);
      add_request(KIND_LEARN, 'hAA, 'h55, 1'b0);
      add_request(KIND_ENCODE, 'hFF, 'h00, 1'b0);
      add_request(KIND_ENCODE, 'h00, 'hFF, 1'b0);
      add_request(KIND_ENCODE, 'h7F, 'h00, 1'b0);
      add_request(KIND_ENCODE, 'h80, 'h00, 1'b0);
      add_request(KIND_DECODE, 'hFF, 'h00, 1'b0);
      add_request(KIND_DECODE, 'h00, 'h05, 1'b0);
      add_request(KIND_DECODE, 'h00, 'h06, 1'b0);
      add_request(KIND_DECODE, 'h00, 'hFF, 1'b0);
      add_request(KIND_NONE, 'hFF, 'hFF, 1'b0);

      // Slow growth with mixed lookups; one pause for a full drain midway
      for (n = 0; n < GROW_BEATS; n++) begin
         random_request(22);
         if (n == GROW_BEATS / 2) pending_requests[$].wait_drain = 1'b1;
      end

      // Fill every remaining byte value in random order
      for (n = 0; n < 256; n++) if (!gen_present[n]) missing.push_back(n);
      for (n = missing.size() - 1; n > 0; n--) begin
         j = $urandom_range(0, n);
         tmp = missing[n];
         missing[n] = missing[j];
         missing[j] = tmp;
      end
      for (n = 0; n < missing.size(); n++) begin
         add_request(KIND_LEARN, missing[n], $urandom_range(0, 255), 1'b0);
         random_request(0);
         random_request(0);
      end

      // Traffic against the full table
      for (n = 0; n < FULL_BEATS; n++) random_request(20);

      total_items = pending_requests.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_cnt == total_items && checked_cnt == total_items);
      repeat (20) @(posedge clock);

      $display("Checked %0d beats: %0d learn, %0d encode, %0d decode, %0d unused kind.",
               checked_cnt, kind_seen[KIND_LEARN], kind_seen[KIND_ENCODE],
               kind_seen[KIND_DECODE], kind_seen[KIND_NONE]);
      $display("Dictionary grew from empty to %0d keys under random idling and backpressure.",
               dict_count);
      if (error_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: %0d of %0d responses checked", checked_cnt, total_items);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
